// File: hdl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Types and constants shared by the sorted priority queue and its cells.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned PRIO_W = 16;
  localparam int unsigned PAY_W = 16;
  localparam int unsigned OCC_W = 5;

  typedef enum logic [1:0] {
    ST_ENQ   = 2'd0,
    ST_FULL  = 2'd1,
    ST_DEQ   = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef enum logic {
    REQ_ENQ = 1'b0,
    REQ_DEQ = 1'b1
  } req_e;

  typedef struct packed {
    logic signed [PRIO_W-1:0] prio;
    logic [PAY_W-1:0]         payload;
  } entry_t;

  // shift commands broadcast to every cell
  typedef struct packed {
    logic enq;
    logic deq;
  } spq_ctrl_t;

endpackage

// File: hdl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: compares its entry with the incoming one and
// holds, loads the new entry, or takes a neighbour's entry.
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
(
  input  logic      clk_i,
  input  spq_ctrl_t ctrl_i,
  input  entry_t    new_i,
  input  logic      valid_i,
  input  logic      prev_take_i,
  input  entry_t    prev_i,
  input  entry_t    next_i,
  output logic      take_o,
  output entry_t    entry_o
);

  entry_t entry_q;
  entry_t entry_d;

  // slot is free or holds a strictly lower priority
  assign take_o = !valid_i || (entry_q.prio < new_i.prio);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.enq) begin
      if (prev_take_i) begin
        entry_d = prev_i;
      end else if (take_o) begin
        entry_d = new_i;
      end
    end else if (ctrl_i.deq) begin
      entry_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// File: hdl/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Priority queue kept sorted in a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Holds up to DEPTH entries sorted from highest to lowest priority, equal
// priorities in arrival order. Every request gives one result beat. Every
// cell compares with the incoming priority in the same cycle, so one request
// is taken per clock unless stalled and its result is in the output register
// on the next cycle; input stall rises only while a result waits unread.
// A full queue rejects an enqueue, an empty queue reports empty on dequeue.
module sorted_priority_queue
  import spq_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     req_type_i,
  input  logic signed [PRIO_W-1:0] prio_i,
  input  logic [PAY_W-1:0]         payload_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [1:0]               status_o,
  output logic signed [PRIO_W-1:0] out_prio_o,
  output logic [PAY_W-1:0]         out_payload_o,
  output logic [OCC_W-1:0]         occupancy_o
);

  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q, out_valid_d;
  status_e          status_q, status_d;
  entry_t           res_q, res_d;

  logic      accept;
  logic      full, empty;
  spq_ctrl_t ctrl;
  entry_t    new_entry;
  entry_t    cell_entry [DEPTH];
  logic      cell_take  [DEPTH];
  logic      cell_valid [DEPTH];

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = (count_q == CNT_W'(DEPTH));
  assign empty      = (count_q == '0);

  assign new_entry.prio    = prio_i;
  assign new_entry.payload = payload_i;

  assign ctrl.enq = accept && (req_type_i == REQ_ENQ) && !full;
  assign ctrl.deq = accept && (req_type_i == REQ_DEQ) && !empty;

  // chain of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign cell_valid[i] = (count_q > CNT_W'(i));
    spq_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .new_i       (new_entry),
      .valid_i     (cell_valid[i]),
      .prev_take_i ((i == 0) ? 1'b0 : cell_take[(i == 0) ? 0 : i - 1]),
      .prev_i      (cell_entry[(i == 0) ? 0 : i - 1]),
      .next_i      (cell_entry[(i == DEPTH - 1) ? i : i + 1]),
      .take_o      (cell_take[i]),
      .entry_o     (cell_entry[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (ctrl.enq) begin
      count_d = count_q + CNT_W'(1);
    end else if (ctrl.deq) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    status_d    = status_q;
    res_d       = res_q;
    if (accept) begin
      out_valid_d = 1'b1;
      res_d       = '0;
      if (req_type_i == REQ_ENQ) begin
        status_d = full ? ST_FULL : ST_ENQ;
      end else if (empty) begin
        status_d = ST_EMPTY;
      end else begin
        status_d = ST_DEQ;
        res_d    = cell_entry[0];
      end
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result beat payload
  logic [CNT_W-1:0] occ_q;

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    res_q    <= res_d;
    if (accept) begin
      occ_q <= count_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign out_prio_o    = res_q.prio;
  assign out_payload_o = res_q.payload;
  assign occupancy_o   = OCC_W'(occ_q);

endmodule

// File: tb/sorted_priority_queue_tb.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_tb
// Self-checking bench for the sorted priority queue.
// ----------------------------------------------------------------------------
// Drives enqueue and dequeue requests over the valid/stall input channel and
// keeps its own sorted copy of the queue to predict every result beat. Each
// result is compared field by field with the oldest prediction. A directed
// run covers the priority extremes, ties, empty and full. A long random run
// follows, with fill-heavy and drain-heavy phases and half of the priorities
// small so that ties are common. Both sides idle at random, apart from one
// quiet stretch; the sender drains after the directed run and once mid-run.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sorted_priority_queue_tb
  import spq_pkg::*;
;

  localparam int unsigned N_RANDOM   = 1350;
  localparam int unsigned IDLE_LIMIT = 2000;

  class queue_scoreboard;
    typedef struct {
      logic signed [PRIO_W-1:0] prio;
      logic [PAY_W-1:0]         payload;
    } slot_t;

    typedef struct {
      status_e                  status;
      logic signed [PRIO_W-1:0] prio;
      logic [PAY_W-1:0]         payload;
      logic [OCC_W-1:0]         occupancy;
    } result_t;

    slot_t   held_entries[$];
    result_t awaited_results[$];
    int      errors = 0;

    function int pending();
      return awaited_results.size();
    endfunction

    function void note_request(req_e kind, logic signed [PRIO_W-1:0] p,
                               logic [PAY_W-1:0] pay);
      result_t r;
      slot_t   s;
      int      pos;
      r.prio = '0;
      r.payload = '0;
      if (kind == REQ_ENQ) begin
        if (held_entries.size() >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          pos = held_entries.size();
          for (int i = 0; i < held_entries.size(); i++) begin
            if ($signed(held_entries[i].prio) < $signed(p)) begin
              pos = i;
              break;
            end
          end
          s.prio = p;
          s.payload = pay;
          held_entries.insert(pos, s);
          r.status = ST_ENQ;
        end
      end else begin
        if (held_entries.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          s = held_entries.pop_front();
          r.status = ST_DEQ;
          r.prio = s.prio;
          r.payload = s.payload;
        end
      end
      r.occupancy = OCC_W'(held_entries.size());
      awaited_results.push_back(r);
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endtask

    task check_result(logic [1:0] st, logic signed [PRIO_W-1:0] p,
                      logic [PAY_W-1:0] pay, logic [OCC_W-1:0] occ);
      result_t r;
      if (awaited_results.size() == 0) begin
        report($sformatf("result beat with no request waiting, status %0d", st));
      end else begin
        r = awaited_results.pop_front();
        if (st !== r.status)
          report($sformatf("status %0d, wanted %s", st, r.status.name()));
        if (p !== r.prio)
          report($sformatf("out_prio %0d, wanted %0d", p, r.prio));
        if (pay !== r.payload)
          report($sformatf("out_payload %h, wanted %h", pay, r.payload));
        if (occ !== r.occupancy)
          report($sformatf("occupancy %0d, wanted %0d", occ, r.occupancy));
      end
    endtask
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     req_type = 1'b0;
  logic signed [PRIO_W-1:0] prio = '0;
  logic [PAY_W-1:0]         payload = '0;
  logic                     out_stall = 1'b0;
  logic                     in_stall_o;
  logic                     out_valid_o;
  logic [1:0]               status_o;
  logic signed [PRIO_W-1:0] out_prio_o;
  logic [PAY_W-1:0]         out_payload_o;
  logic [OCC_W-1:0]         occupancy_o;

  bit              quiet = 1'b0;
  int unsigned     idle_cycles = 0;
  queue_scoreboard book;

  sorted_priority_queue dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type),
    .prio_i        (prio),
    .payload_i     (payload),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall),
    .status_o      (status_o),
    .out_prio_o    (out_prio_o),
    .out_payload_o (out_payload_o),
    .occupancy_o   (occupancy_o)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 38);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid_o && !out_stall)
      book.check_result(status_o, out_prio_o, out_payload_o, occupancy_o);
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send_item(req_e kind, logic signed [PRIO_W-1:0] p,
                           logic [PAY_W-1:0] pay);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    prio <= p;
    payload <= pay;
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
    book.note_request(kind, p, pay);
  endtask

  task automatic wait_for_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (book.pending() != 0) @(negedge clk);
  endtask

  function automatic logic signed [PRIO_W-1:0] pick_prio();
    int r;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: begin
        r = int'($urandom_range(6)) - 3;
        return r[PRIO_W-1:0];
      end
      5, 6: begin
        case ($urandom_range(3))
          0: return 16'sh8000;
          1: return 16'sh7fff;
          2: return 16'sh0000;
          default: return 16'shffff;
        endcase
      end
      default: return PRIO_W'($urandom());
    endcase
  endfunction

  initial begin
    int enq_pct;
    book = new();
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty, extremes, ties, fill to full, reject
    send_item(REQ_DEQ, 16'shffff, 16'hffff);
    send_item(REQ_ENQ, 16'sh7fff, 16'hffff);
    send_item(REQ_ENQ, 16'sh8000, 16'h0000);
    send_item(REQ_ENQ, 16'sh0000, 16'h0001);
    send_item(REQ_ENQ, 16'sh0005, 16'haaaa);
    send_item(REQ_ENQ, 16'sh0005, 16'h5555);
    send_item(REQ_ENQ, 16'sh0005, 16'h0f0f);
    send_item(REQ_ENQ, 16'shffff, 16'h1234);
    send_item(REQ_ENQ, 16'sh7fff, 16'h0001);
    send_item(REQ_DEQ, 16'sh0000, 16'h0000);
    send_item(REQ_DEQ, 16'sh7fff, 16'hffff);
    send_item(REQ_DEQ, 16'sh8000, 16'h0000);
    for (int i = 0; i < 12; i++)
      send_item(REQ_ENQ, PRIO_W'(i - 6), PAY_W'(16'hc000 + i));
    send_item(REQ_DEQ, 16'sh1234, 16'hbeef);
    wait_for_drain();

    for (int n = 0; n < N_RANDOM; n++) begin
      quiet = (n >= 400 && n < 650);
      if (n == 800)
        wait_for_drain();
      case ((n / 60) % 3)
        0: enq_pct = 75;
        1: enq_pct = 25;
        default: enq_pct = 50;
      endcase
      if ($urandom_range(99) < enq_pct)
        send_item(REQ_ENQ, pick_prio(), PAY_W'($urandom()));
      else
        send_item(REQ_DEQ, PRIO_W'($urandom()), PAY_W'($urandom()));
    end
    quiet = 1'b0;

    @(negedge clk);
    in_valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (book.errors == 0 && book.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/sorted_priority_queue.sv
tb/sorted_priority_queue_tb.sv
